// ===== rtl/core/pmrr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmrr_pkg
// Types and fixed constants of the palette megatile row renderer.
// ----------------------------------------------------------------------------
package pmrr_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    OP_PALETTE = 2'd0,
    OP_PIXEL   = 2'd1,
    OP_REF     = 2'd2,
    OP_RENDER  = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_REF_COUNT      = 2'd0,
    CFG_MINITILE_COUNT = 2'd1,
    CFG_REF_WIDE       = 2'd2
  } cfg_e;

  localparam int MEGA_SIZE     = 32;
  localparam int MINI_SIZE     = 8;
  localparam int SPANS         = MEGA_SIZE / MINI_SIZE;
  localparam int REFS_PER_MEGA = 16;
  localparam int PIX_PER_MINI  = 64;
  localparam int PAL_DEPTH     = 256;

  localparam int RGB_W       = 24;
  localparam int REF_W       = 32;
  localparam int PIXIDX_W    = 8;
  localparam int ADDR_W      = 17;
  localparam int MEGA_W      = 10;
  localparam int ROW_W       = 5;
  localparam int SPAN_W      = 2;
  localparam int REFCNT_W    = 15;
  localparam int MINICNT_W   = 12;
  localparam int CFG_DATA_W  = 15;
  localparam int IN_DATA_W   = 72;

  localparam logic [SPAN_W-1:0] LAST_SPAN = SPAN_W'(SPANS - 1);

endpackage
`default_nettype wire

// ===== rtl/core/palette_megatile_row_renderer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// palette_megatile_row_renderer_top
// Palette-indexed 32x32 megatile row renderer with reference, pixel and
// palette stores loaded through the input stream.
// ----------------------------------------------------------------------------
// A render transfer yields four output transfers, one 8-pixel span per
// minitile column, left to right; it blocks input until all four spans
// have issued, as the reference table has one read port and the pixel banks
// deliver one minitile row per cycle unless the output stalls. Write
// transfers (palette, pixel byte, reference) yield nothing. The pipeline of
// reference, pixel and palette reads and output register stalls only while a
// finished span waits at the output. Stores power up undefined and need no
// clearing pass; reads of never-written entries give arbitrary pixels.
// Configuration must be written only while idle; the block does not enforce it.

module palette_megatile_row_renderer_top #(
  parameter int MEGATILE_DEPTH = 1024,
  parameter int MINITILE_DEPTH = 2048
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,

  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_addr_i,
  input  wire logic [14:0]  cfg_wdata_i,

  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // op[1:0], mem_address[18:2], write_value[50:19], megatile_id[60:51],
  // pixel_row[65:61], zero[71:66]
  input  wire logic [71:0]  s_axis_tdata,

  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pixel_0[23:0], pixel_1[47:24], ... pixel_7[191:168]
  output logic [191:0]      m_axis_tdata,
  // span_column[1:0]
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  localparam int REF_DEPTH = MEGATILE_DEPTH * pmrr_pkg::REFS_PER_MEGA;
  localparam int REF_AW    = $clog2(REF_DEPTH);
  localparam int PXR_DEPTH = MINITILE_DEPTH * pmrr_pkg::MINI_SIZE;
  localparam int PXR_AW    = $clog2(PXR_DEPTH);
  localparam int PIX_DEPTH = MINITILE_DEPTH * pmrr_pkg::PIX_PER_MINI;
  localparam int NPIX      = pmrr_pkg::MINI_SIZE;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [pmrr_pkg::REFCNT_W-1:0]  ref_count_q;
  logic [pmrr_pkg::MINICNT_W-1:0] minitile_count_q;
  logic                           ref_wide_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_count_q      <= '0;
      minitile_count_q <= '0;
      ref_wide_q       <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pmrr_pkg::CFG_REF_COUNT:      ref_count_q <= cfg_wdata_i[pmrr_pkg::REFCNT_W-1:0];
        pmrr_pkg::CFG_MINITILE_COUNT: minitile_count_q <=
                                        cfg_wdata_i[pmrr_pkg::MINICNT_W-1:0];
        pmrr_pkg::CFG_REF_WIDE:       ref_wide_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves together; it stalls only while the output is held.
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;

  // --------------------------------------------------------------------------
  // Issue: a render item is expanded into four span requests
  // --------------------------------------------------------------------------
  pmrr_pkg::op_e                  in_op;
  logic [pmrr_pkg::ADDR_W-1:0]    in_addr;
  logic [pmrr_pkg::REF_W-1:0]     in_val;
  logic [pmrr_pkg::MEGA_W-1:0]    in_mega;
  logic [pmrr_pkg::ROW_W-1:0]     in_row;

  assign in_op   = pmrr_pkg::op_e'(s_axis_tdata[1:0]);
  assign in_addr = s_axis_tdata[18:2];
  assign in_val  = s_axis_tdata[50:19];
  assign in_mega = s_axis_tdata[60:51];
  assign in_row  = s_axis_tdata[65:61];

  logic                          busy_q;
  logic [pmrr_pkg::SPAN_W-1:0]   span_q;
  logic [pmrr_pkg::MEGA_W-1:0]   hold_mega_q;
  logic [pmrr_pkg::ROW_W-1:0]    hold_row_q;

  logic                          acc;
  logic                          iss_vld;
  pmrr_pkg::op_e                 iss_op;
  logic [pmrr_pkg::MEGA_W-1:0]   iss_mega;
  logic [pmrr_pkg::ROW_W-1:0]    iss_row;
  logic [pmrr_pkg::SPAN_W-1:0]   iss_span;
  logic [13:0]                   iss_entry;
  logic                          iss_entry_ok;

  assign s_axis_tready = adv && !busy_q;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign iss_vld       = acc || (busy_q && adv);
  assign iss_op        = busy_q ? pmrr_pkg::OP_RENDER : in_op;
  assign iss_mega      = busy_q ? hold_mega_q : in_mega;
  assign iss_row       = busy_q ? hold_row_q : in_row;
  assign iss_span      = busy_q ? span_q : '0;
  // mega*16 + (row/8)*4 + span
  assign iss_entry     = {iss_mega, iss_row[4:3], iss_span};
  assign iss_entry_ok  = (32'(iss_entry) < 32'(ref_count_q)) &&
                         (32'(iss_entry) < 32'(REF_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      span_q <= '0;
    end else if (adv) begin
      if (acc && in_op == pmrr_pkg::OP_RENDER) begin
        busy_q <= 1'b1;
        span_q <= pmrr_pkg::SPAN_W'(1);
      end else if (busy_q) begin
        span_q <= span_q + pmrr_pkg::SPAN_W'(1);
        if (span_q == pmrr_pkg::LAST_SPAN) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      hold_mega_q <= in_mega;
      hold_row_q  <= in_row;
    end
  end

  // Reference table, written and read at the issue point
  logic [pmrr_pkg::REF_W-1:0] ref_rd;
  logic                       ref_we;

  assign ref_we = adv && acc && in_op == pmrr_pkg::OP_REF &&
                  (32'(in_addr) < 32'(REF_DEPTH));

  pmrr_ram #(
    .WIDTH (pmrr_pkg::REF_W),
    .DEPTH (REF_DEPTH),
    .AW    (REF_AW)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (REF_AW'(32'(in_addr))),
    .wdata_i (in_val),
    .re_i    (adv),
    .raddr_i (REF_AW'(32'(iss_entry))),
    .rdata_o (ref_rd)
  );

  // --------------------------------------------------------------------------
  // Stage 1: reference word -> minitile, flip; pixel row read
  // --------------------------------------------------------------------------
  logic                          p1_vld_q;
  pmrr_pkg::op_e                 p1_op_q;
  logic [pmrr_pkg::ADDR_W-1:0]   p1_addr_q;
  logic [pmrr_pkg::RGB_W-1:0]    p1_val_q;
  logic [pmrr_pkg::SPAN_W-1:0]   p1_span_q;
  logic [2:0]                    p1_row3_q;
  logic                          p1_entry_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (adv) begin
      p1_vld_q <= iss_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_op_q       <= iss_op;
      p1_addr_q     <= in_addr;
      p1_val_q      <= in_val[pmrr_pkg::RGB_W-1:0];
      p1_span_q     <= iss_span;
      p1_row3_q     <= iss_row[2:0];
      p1_entry_ok_q <= iss_entry_ok;
    end
  end

  logic [pmrr_pkg::REF_W-1:0] ref_word;
  logic [30:0]                p1_mini;
  logic                       p1_ok;
  logic [PXR_AW-1:0]          pix_raddr;
  logic [PXR_AW-1:0]          pix_waddr;
  logic                       pix_wr;

  assign ref_word  = ref_wide_q ? ref_rd : {16'b0, ref_rd[15:0]};
  assign p1_mini   = ref_word[31:1];
  assign p1_ok     = p1_entry_ok_q &&
                     (32'(p1_mini) < 32'(minitile_count_q)) &&
                     (32'(p1_mini) < 32'(MINITILE_DEPTH));
  assign pix_raddr = PXR_AW'({p1_mini, p1_row3_q});
  assign pix_waddr = PXR_AW'(p1_addr_q[16:3]);
  assign pix_wr    = adv && p1_vld_q && p1_op_q == pmrr_pkg::OP_PIXEL &&
                     (32'(p1_addr_q) < 32'(PIX_DEPTH));

  // Eight byte banks, one per pixel column, so a whole minitile row is read at once
  logic [pmrr_pkg::PIXIDX_W-1:0] pix_rd [NPIX];

  for (genvar b = 0; b < NPIX; b++) begin : g_pix_bank
    pmrr_ram #(
      .WIDTH (pmrr_pkg::PIXIDX_W),
      .DEPTH (PXR_DEPTH),
      .AW    (PXR_AW)
    ) u_pix_ram (
      .clk_i   (clk_i),
      .we_i    (pix_wr && (p1_addr_q[2:0] == 3'(b))),
      .waddr_i (pix_waddr),
      .wdata_i (p1_val_q[pmrr_pkg::PIXIDX_W-1:0]),
      .re_i    (adv),
      .raddr_i (pix_raddr),
      .rdata_o (pix_rd[b])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 2: flip and palette lookup
  // --------------------------------------------------------------------------
  logic                          p2_vld_q;
  pmrr_pkg::op_e                 p2_op_q;
  logic [pmrr_pkg::ADDR_W-1:0]   p2_addr_q;
  logic [pmrr_pkg::RGB_W-1:0]    p2_val_q;
  logic [pmrr_pkg::SPAN_W-1:0]   p2_span_q;
  logic                          p2_ok_q;
  logic                          p2_flip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (adv) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_op_q   <= p1_op_q;
      p2_addr_q <= p1_addr_q;
      p2_val_q  <= p1_val_q;
      p2_span_q <= p1_span_q;
      p2_ok_q   <= p1_ok;
      p2_flip_q <= ref_word[0];
    end
  end

  logic                       pal_wr;
  logic [pmrr_pkg::RGB_W-1:0] pal_rd [NPIX];

  assign pal_wr = adv && p2_vld_q && p2_op_q == pmrr_pkg::OP_PALETTE &&
                  (32'(p2_addr_q) < 32'(pmrr_pkg::PAL_DEPTH));

  // One palette copy per output column; all copies take every write
  for (genvar x = 0; x < NPIX; x++) begin : g_pal_copy
    logic [pmrr_pkg::PIXIDX_W-1:0] pal_idx;
    assign pal_idx = p2_flip_q ? pix_rd[NPIX-1-x] : pix_rd[x];

    pmrr_ram #(
      .WIDTH (pmrr_pkg::RGB_W),
      .DEPTH (pmrr_pkg::PAL_DEPTH),
      .AW    (pmrr_pkg::PIXIDX_W)
    ) u_pal_ram (
      .clk_i   (clk_i),
      .we_i    (pal_wr),
      .waddr_i (p2_addr_q[pmrr_pkg::PIXIDX_W-1:0]),
      .wdata_i (p2_val_q),
      .re_i    (adv),
      .raddr_i (pal_idx),
      .rdata_o (pal_rd[x])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 3: black masking, output register
  // --------------------------------------------------------------------------
  logic                          p3_vld_q;
  logic                          p3_render_q;
  logic [pmrr_pkg::SPAN_W-1:0]   p3_span_q;
  logic                          p3_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else if (adv) begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_render_q <= (p2_op_q == pmrr_pkg::OP_RENDER);
      p3_span_q   <= p2_span_q;
      p3_ok_q     <= p2_ok_q;
    end
  end

  logic                          out_vld_q;
  logic [191:0]                  out_data_q;
  logic [191:0]                  out_data_d;
  logic [pmrr_pkg::SPAN_W-1:0]   out_span_q;
  logic                          out_last_q;

  for (genvar x = 0; x < NPIX; x++) begin : g_out_pix
    assign out_data_d[x*pmrr_pkg::RGB_W +: pmrr_pkg::RGB_W] = p3_ok_q ? pal_rd[x] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= p3_vld_q && p3_render_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_span_q <= p3_span_q;
      out_last_q <= (p3_span_q == pmrr_pkg::LAST_SPAN);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_span_q;
  assign m_axis_tlast  = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready)
    else $error("input accepted while spans still issuing");

  a_last_on_final_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == pmrr_pkg::LAST_SPAN))
    else $error("tlast on a span other than the last column");

  a_issue_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && busy_q && span_q == pmrr_pkg::LAST_SPAN) |=> !busy_q)
    else $error("span issue did not end after the fourth span");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({p1_vld_q, p2_vld_q, p3_vld_q}))
    else $error("pipeline valid bits moved during a stall");

endmodule
`default_nettype wire

// ===== rtl/core/pmrr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmrr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pmrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== tb/pmrr_row_checker.sv =====
// ----------------------------------------------------------------------------
// pmrr_row_checker
// Watches the config port and both stream channels of the megatile row
// renderer, keeps its own palette, pixel and reference stores, predicts the
// four spans of every render transfer and compares them with the output.
// ----------------------------------------------------------------------------
module pmrr_row_checker
  import pmrr_pkg::*;
#(
  parameter int MEGATILE_DEPTH = 1024,
  parameter int MINITILE_DEPTH = 2048
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [14:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // op[1:0], mem_address[18:2], write_value[50:19], megatile_id[60:51],
  // pixel_row[65:61], zero[71:66]
  input  logic [71:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_0[23:0], pixel_1[47:24], ... pixel_7[191:168]
  input  logic [191:0] m_axis_tdata,
  // span_column[1:0]
  input  logic [1:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           errors_o,
  output int           pending_o
);

  localparam int REF_DEPTH = MEGATILE_DEPTH * REFS_PER_MEGA;
  localparam int PIX_DEPTH = MINITILE_DEPTH * PIX_PER_MINI;

  typedef struct packed {
    logic [MINI_SIZE-1:0][RGB_W-1:0] rgb;
    logic [SPAN_W-1:0]               column;
    logic                            last;
  } span_t;

  logic [RGB_W-1:0]     palette_mem [PAL_DEPTH];
  logic [PIXIDX_W-1:0]  pixel_mem   [PIX_DEPTH];
  logic [REF_W-1:0]     ref_mem     [REF_DEPTH];
  logic [REFCNT_W-1:0]  ref_count;
  logic [MINICNT_W-1:0] mini_count;
  logic                 ref_wide;
  span_t                span_q[$];
  int                   errors = 0;

  function automatic void predict_row(input logic [MEGA_W-1:0] mega,
                                      input logic [ROW_W-1:0]  row);
    int unsigned      rlim, mlim, entry, mini, pa, sx;
    logic [REF_W-1:0] word;
    bit               flip, hit;
    span_t            sp;
    rlim = (ref_count < REF_DEPTH) ? ref_count : REF_DEPTH;
    mlim = (mini_count < MINITILE_DEPTH) ? mini_count : MINITILE_DEPTH;
    for (int c = 0; c < SPANS; c++) begin
      entry = mega * REFS_PER_MEGA + (row / MINI_SIZE) * SPANS + c;
      hit   = 1'b0;
      mini  = 0;
      flip  = 1'b0;
      if (entry < rlim) begin
        word = ref_mem[entry];
        if (!ref_wide) word[REF_W-1:16] = '0;
        mini = word >> 1;
        flip = word[0];
        hit  = (mini < mlim);
      end
      for (int x = 0; x < MINI_SIZE; x++) begin
        sp.rgb[x] = '0;
        if (hit) begin
          sx = flip ? (MINI_SIZE - 1 - x) : x;
          pa = mini * PIX_PER_MINI + (row % MINI_SIZE) * MINI_SIZE + sx;
          sp.rgb[x] = palette_mem[pixel_mem[pa]];
        end
      end
      sp.column = SPAN_W'(c);
      sp.last   = (c == SPANS - 1);
      span_q.push_back(sp);
    end
  endfunction

  function automatic void absorb_item(input logic [71:0] d);
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [REF_W-1:0]  val;
    op   = op_e'(d[1:0]);
    addr = d[2 +: ADDR_W];
    val  = d[19 +: REF_W];
    case (op)
      OP_PALETTE: if (addr < PAL_DEPTH) palette_mem[addr] = val[RGB_W-1:0];
      OP_PIXEL:   if (addr < PIX_DEPTH) pixel_mem[addr] = val[PIXIDX_W-1:0];
      OP_REF:     if (addr < REF_DEPTH) ref_mem[addr] = val;
      default:    predict_row(d[51 +: MEGA_W], d[61 +: ROW_W]);
    endcase
  endfunction

  function automatic void check_span();
    span_t want;
    if (span_q.size() == 0) begin
      $display("%0t: span with no render pending, column %0d last %0b", $time,
               m_axis_tuser, m_axis_tlast);
      errors++;
      return;
    end
    want = span_q.pop_front();
    for (int x = 0; x < MINI_SIZE; x++) begin
      if (m_axis_tdata[x*RGB_W +: RGB_W] !== want.rgb[x]) begin
        $display("%0t: column %0d pixel_%0d expected %06h got %06h", $time,
                 want.column, x, want.rgb[x], m_axis_tdata[x*RGB_W +: RGB_W]);
        errors++;
      end
    end
    if (m_axis_tuser !== want.column) begin
      $display("%0t: span_column expected %0d got %0d", $time, want.column,
               m_axis_tuser);
      errors++;
    end
    if (m_axis_tlast !== want.last) begin
      $display("%0t: last_span on column %0d expected %0b got %0b", $time,
               want.column, want.last, m_axis_tlast);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_count  = '0;
      mini_count = '0;
      ref_wide   = 1'b1;
      span_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_REF_COUNT:      ref_count = cfg_wdata_i[REFCNT_W-1:0];
          CFG_MINITILE_COUNT: mini_count = cfg_wdata_i[MINICNT_W-1:0];
          CFG_REF_WIDE:       ref_wide = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) absorb_item(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_span();
    end
    pending_o <= span_q.size();
    errors_o  <= errors;
  end

endmodule

// ===== tb/tb_palette_megatile_row_renderer_top.sv =====
// ----------------------------------------------------------------------------
// tb_palette_megatile_row_renderer_top
// Drives loads and render rows into the megatile row renderer under random
// stalls on both streams and several register settings; every store entry a
// render will read is loaded first. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_palette_megatile_row_renderer_top;
  import pmrr_pkg::*;

  localparam int MEGATILE_DEPTH = 1024;
  localparam int MINITILE_DEPTH = 2048;
  localparam int REF_DEPTH      = MEGATILE_DEPTH * REFS_PER_MEGA;
  localparam int PIX_DEPTH      = MINITILE_DEPTH * PIX_PER_MINI;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam int PHASES         = 6;

  localparam logic [7:0] ROW0_BYTES [MINI_SIZE] = '{8'd0, 8'd255, 8'd255, 8'd0,
                                                    8'd0, 8'd0, 8'd0, 8'd255};

  logic         clk       = 1'b0;
  logic         rst_n     = 1'b0;
  logic         cfg_we    = 1'b0;
  logic [1:0]   cfg_addr  = '0;
  logic [14:0]  cfg_wdata = '0;
  logic         s_valid   = 1'b0;
  logic [71:0]  s_data    = '0;
  logic         m_ready   = 1'b0;
  logic         s_ready;
  logic         m_valid;
  logic [191:0] m_data;
  logic [1:0]   m_user;
  logic         m_last;
  int           chk_errors;
  int           chk_pending;

  // Stimulus-side view of what has been loaded, so no render reads an
  // entry that was never written.
  logic [REF_W-1:0]    ref_shadow [REF_DEPTH];
  bit                  ref_known  [REF_DEPTH];
  logic [PIXIDX_W-1:0] pix_shadow [PIX_DEPTH];
  bit                  pix_known  [PIX_DEPTH];
  bit                  pal_known  [PAL_DEPTH];
  int unsigned         ref_lim;
  int unsigned         mini_lim;
  bit                  narrow_refs;

  bit tx_burst    = 1'b0;
  int items_sent  = 0;
  int rows_sent   = 0;
  int stall_asks  = 0;
  int stall_seen  = 0;
  int cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  palette_megatile_row_renderer_top #(
    .MEGATILE_DEPTH(MEGATILE_DEPTH),
    .MINITILE_DEPTH(MINITILE_DEPTH)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user),
    .m_axis_tlast (m_last)
  );

  pmrr_row_checker #(
    .MEGATILE_DEPTH(MEGATILE_DEPTH),
    .MINITILE_DEPTH(MINITILE_DEPTH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user),
    .m_axis_tlast (m_last),
    .errors_o     (chk_errors),
    .pending_o    (chk_pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_palette_megatile_row_renderer_top: errors");
      $finish;
    end
  end

  // Output side: random back-pressure, occasional free-running stretches and
  // one long hold-off when the stimulus asks for it.
  initial begin : rx_side
    int idle_left;
    int free_left;
    int k;
    idle_left = 0;
    free_left = 0;
    forever begin
      @(posedge clk);
      if (stall_seen != stall_asks) begin
        stall_seen = stall_asks;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_ready <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        m_ready <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        k = $urandom_range(0, 99);
        if (k < 20) idle_left = $urandom_range(1, 3);
        else if (k < 25) idle_left = $urandom_range(10, 40);
        else if (k < 28) free_left = $urandom_range(40, 150);
      end
    end
  end

  function automatic int tx_gap();
    int k;
    if (tx_burst) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Valid stays high across back-to-back transfers; it is only lowered for a gap.
  task automatic push_item(input op_e op, input logic [ADDR_W-1:0] addr,
                           input logic [REF_W-1:0] val, input logic [MEGA_W-1:0] mega,
                           input logic [ROW_W-1:0] row);
    int gap;
    case (op)
      OP_PALETTE: if (addr < PAL_DEPTH) pal_known[addr] = 1'b1;
      OP_PIXEL: if (addr < PIX_DEPTH) begin
        pix_known[addr]  = 1'b1;
        pix_shadow[addr] = val[PIXIDX_W-1:0];
      end
      OP_REF: if (addr < REF_DEPTH) begin
        ref_known[addr]  = 1'b1;
        ref_shadow[addr] = val;
      end
      default: ;
    endcase
    s_valid <= 1'b1;
    s_data  <= {6'b0, row, mega, val, addr, op};
    do @(posedge clk); while (!s_ready);
    items_sent++;
    gap = tx_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    s_valid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [14:0] rc, input logic [14:0] mc,
                            input logic [14:0] wide);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_REF_COUNT;
    cfg_wdata <= rc;
    @(posedge clk);
    cfg_addr  <= CFG_MINITILE_COUNT;
    cfg_wdata <= mc;
    @(posedge clk);
    cfg_addr  <= CFG_REF_WIDE;
    cfg_wdata <= wide;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ref_lim     = (rc < REF_DEPTH) ? rc : REF_DEPTH;
    mini_lim    = (mc[MINICNT_W-1:0] < MINITILE_DEPTH) ? mc[MINICNT_W-1:0] : MINITILE_DEPTH;
    narrow_refs = !wide[0];
  endtask

  // Low 16 bits carry a small pool of minitiles; upper half is often zero so
  // wide and narrow references both reach real pixels.
  function automatic logic [REF_W-1:0] pick_ref_word();
    logic [14:0] mini;
    logic [15:0] hi;
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4, 5: mini = 15'($urandom_range(0, 1));
      6:                mini = 15'(MINITILE_DEPTH - 1);
      default:          mini = 15'($urandom_range(0, 4095));
    endcase
    hi = $urandom_range(0, 1) ? 16'h0 : 16'($urandom);
    return {hi, mini, 1'($urandom)};
  endfunction

  function automatic logic [PIXIDX_W-1:0] pick_index();
    return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  function automatic logic [MEGA_W-1:0] pick_mega();
    int k;
    k = $urandom_range(0, 9);
    if (k < 8) return MEGA_W'($urandom_range(0, 1));
    if (k == 8) return '1;
    return MEGA_W'($urandom);
  endfunction

  // Any minitile row group, but only two rows inside a minitile, so the
  // pixel loads stay few.
  function automatic logic [ROW_W-1:0] pick_row();
    logic [2:0] y;
    y = $urandom_range(0, 1) ? 3'd0 : 3'd5;
    return {2'($urandom), y};
  endfunction

  // Loads every reference, pixel byte and palette entry the row will read.
  task automatic load_for_row(input logic [MEGA_W-1:0] mega, input logic [ROW_W-1:0] row);
    int unsigned      entry, mini, pa;
    logic [REF_W-1:0] word;
    for (int c = 0; c < SPANS; c++) begin
      entry = mega * REFS_PER_MEGA + (row / MINI_SIZE) * SPANS + c;
      if (entry < ref_lim) begin
        if (!ref_known[entry])
          push_item(OP_REF, ADDR_W'(entry), pick_ref_word(), MEGA_W'($urandom),
                    ROW_W'($urandom));
        word = ref_shadow[entry];
        if (narrow_refs) word[REF_W-1:16] = '0;
        mini = word >> 1;
        if (mini < mini_lim) begin
          for (int x = 0; x < MINI_SIZE; x++) begin
            pa = mini * PIX_PER_MINI + (row % MINI_SIZE) * MINI_SIZE + x;
            if (!pix_known[pa])
              push_item(OP_PIXEL, ADDR_W'(pa), {24'($urandom), pick_index()},
                        MEGA_W'($urandom), ROW_W'($urandom));
            if (!pal_known[pix_shadow[pa]])
              push_item(OP_PALETTE, ADDR_W'(pix_shadow[pa]), $urandom,
                        MEGA_W'($urandom), ROW_W'($urandom));
          end
        end
      end
    end
  endtask

  task automatic render_row(input logic [MEGA_W-1:0] mega, input logic [ROW_W-1:0] row);
    load_for_row(mega, row);
    push_item(OP_RENDER, ADDR_W'($urandom), $urandom, mega, row);
    rows_sent++;
  endtask

  task automatic random_item();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) begin
      render_row(pick_mega(), pick_row());
    end else if (k < 75) begin
      push_item(OP_REF,
                $urandom_range(0, 3) == 0 ? ADDR_W'($urandom) : ADDR_W'($urandom_range(0, 63)),
                pick_ref_word(), MEGA_W'($urandom), ROW_W'($urandom));
    end else if (k < 90) begin
      push_item(OP_PIXEL, ADDR_W'($urandom), $urandom, MEGA_W'($urandom), ROW_W'($urandom));
    end else begin
      push_item(OP_PALETTE,
                $urandom_range(0, 3) == 0 ? ADDR_W'($urandom)
                                          : ADDR_W'($urandom_range(0, 2 * PAL_DEPTH - 1)),
                $urandom, MEGA_W'($urandom), ROW_W'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [14:0] ph_rc   [PHASES];
    logic [11:0] ph_mc   [PHASES];
    bit          ph_wide [PHASES];
    int          first_item;
    int          first_row;
    ph_rc   = '{15'd32767, 15'd64, 15'd0, 15'd16384, 15'($urandom), 15'd32767};
    ph_mc   = '{12'd4095, 12'd8, 12'd2048, 12'd0, 12'($urandom), 12'd16};
    ph_wide = '{1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom), 1'b1};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one minitile row, plain, flipped, at the minitile count,
    // wide vs narrow reference, out-of-range writes ignored.
    set_config(15'd16, 15'd1, 15'd1);
    push_item(OP_PALETTE, ADDR_W'(0), 32'hFFFF_FFFF, '0, '0);
    push_item(OP_PALETTE, ADDR_W'(255), 32'h0012_3456, '1, '1);
    push_item(OP_PALETTE, ADDR_W'(256), $urandom, '0, '0);
    push_item(OP_PALETTE, '1, $urandom, '1, '1);
    for (int x = 0; x < MINI_SIZE; x++)
      push_item(OP_PIXEL, ADDR_W'(x), {24'hFFFFFF, ROW0_BYTES[x]}, '0, '0);
    push_item(OP_PIXEL, '1, 32'hFFFF_FF00, '0, '0);
    push_item(OP_REF, ADDR_W'(0), 32'h0000_0000, '0, '0);
    push_item(OP_REF, ADDR_W'(1), 32'h0000_0001, '0, '0);
    push_item(OP_REF, ADDR_W'(2), 32'h0000_0002, '0, '0);
    push_item(OP_REF, ADDR_W'(3), 32'hFFFF_0000, '0, '0);
    push_item(OP_REF, ADDR_W'(REF_DEPTH - 1), $urandom, '0, '0);
    push_item(OP_REF, '1, $urandom, '0, '0);
    render_row('0, '0);
    quiesce();
    set_config(15'd4, {3'b111, 12'd1}, {14'h3FFF, 1'b0});
    render_row('0, '0);
    render_row('0, '1);
    render_row('1, '1);

    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      set_config(ph_rc[ph], {3'($urandom), ph_mc[ph]}, {14'($urandom), ph_wide[ph]});
      tx_burst   = (ph % 3 == 1);
      first_item = items_sent;
      first_row  = rows_sent;
      if (ph == 0) begin
        // Long output hold-off while rows keep coming, then drain fully.
        stall_asks++;
        for (int i = 0; i < 6; i++) render_row(MEGA_W'($urandom_range(0, 1)), pick_row());
        quiesce();
      end
      while (items_sent - first_item < 8 || rows_sent - first_row < 3) random_item();
    end

    quiesce();
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("tb_palette_megatile_row_renderer_top: clean");
    end else begin
      $display("tb_palette_megatile_row_renderer_top: errors");
    end
    $finish;
  end

endmodule
